@@ hdl/lzbd_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants of the bit-packed LZ77 block decompressor.
// No dependencies; used by the top level and the checker.
package lzbd_pkg;

    localparam logic [1:0] MODE_IDLE  = 2'd0;
    localparam logic [1:0] MODE_WORD  = 2'd1;
    localparam logic [1:0] MODE_BLOCK = 2'd2;

    localparam logic CFG_BLOCK_LENGTH = 1'b0;
    localparam logic CFG_MIN_MATCH    = 1'b1;

    localparam int BLOCK_LEN_W = 17;
    localparam int MIN_MATCH_W = 4;

    typedef enum logic [2:0] {
        PH_IDLE     = 3'd0,
        PH_FLAG     = 3'd1,
        PH_LITCNT   = 3'd2,
        PH_DIST     = 3'd3,
        PH_CNT      = 3'd4,
        PH_LITBYTES = 3'd5,
        PH_COPY     = 3'd6
    } t_phase;

    typedef struct packed {
        logic       taken;
        logic       byte_valid;
        logic       is_copy;
        logic       fwd;
        logic       last;
        logic       ovf;
        logic [7:0] lit;
    } t_stage;

    typedef struct packed {
        logic       taken;
        logic       byte_valid;
        logic [7:0] data;
        logic       last;
        logic       ovf;
    } t_result;

endpackage

@@ hdl/lzbd_ram.sv @@
`timescale 1ns / 1ps
// Generic single-clock RAM: one write port, one read port, registered read data.
// No dependencies.
module lzbd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 65536
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ hdl/lz77_bit_packed_decompressor.sv @@
`timescale 1ns / 1ps
// Top level of the bit-packed LZ77 block decompressor.
// Depends on lzbd_pkg and lzbd_ram (history memory).
//
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries one tick: i_mode and
//   i_data_word. Mode 2 starts a block with the group-width word, mode 1
//   offers a stream word, mode 0 is an idle tick. Every tick yields exactly
//   one result on the output channel (o_out_valid / i_out_ready): whether the
//   word was taken, and at most one decompressed byte with block-end and
//   overflow marks. Configuration (i_cfg_valid / o_cfg_ready) writes
//   block_length (index 0) and min_match (index 1) between blocks.
//   Each result goes through a stage register and then the output register.
//   Throughput: one tick per cycle while the receiver does not stall; a
//   stream tick waits while a flag or number chunk is left to decode, as the
//   decoder takes one flag or chunk per cycle. Copy bytes come from the
//   history RAM the cycle after the read; a copy of the byte just written
//   is forwarded. Reset is synchronous; it clears control state and sets
//   block_length to 65536 and min_match to 3. The history RAM is not cleared.
//   When the receiver stalls, the output register holds and one more result
//   waits in the pipeline; input transfers stop until they drain.
module lz77_bit_packed_decompressor
    import lzbd_pkg::*;
#(
    parameter int HISTORY_BYTES = 65536
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  logic [1:0]             i_mode,
    input  logic [31:0]            i_data_word,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output logic                   o_word_taken,
    output logic                   o_byte_valid,
    output logic [7:0]             o_out_byte,
    output logic                   o_block_end,
    output logic                   o_overflow,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic                   i_cfg_index,
    input  logic [BLOCK_LEN_W-1:0] i_cfg_data
);

    localparam int AW = $clog2(HISTORY_BYTES);

    logic [63:0]            r_buf, n_buf;
    logic [6:0]             r_cnt, n_cnt;
    logic [4:0]             r_glit, n_glit, r_gdist, n_gdist, r_gcnt, n_gcnt;
    t_phase                 r_phase, n_phase;
    logic [AW-1:0]          r_num, n_num;
    logic [5:0]             r_nshift, n_nshift;
    logic [AW:0]            r_dist, n_dist;
    logic [AW:0]            r_run, n_run;
    logic [BLOCK_LEN_W-1:0] r_brem, n_brem;
    logic [AW-1:0]          r_wp, n_wp;
    logic                   r_tovf, n_tovf;
    logic [BLOCK_LEN_W-1:0] r_blen, n_blen;
    logic [MIN_MATCH_W-1:0] r_minm, n_minm;

    logic                   r_b_valid, n_b_valid;
    t_stage                 r_b, n_b;
    logic [AW-1:0]          r_b_wp, n_b_wp;
    logic [7:0]             r_fwd_byte, n_fwd_byte;
    logic                   r_out_valid, n_out_valid;
    t_result                r_out, n_out;

    logic [4:0]             len;
    logic [5:0]             need;
    logic                   dec_pend, is_blk, b_go, acc;
    logic [31:0]            chunk;
    logic                   more;
    logic [63:0]            wide;
    logic                   csat;
    logic [AW-1:0]          fv;
    logic [6:0]             shsum;
    logic [AW-1:0]          src;
    logic [7:0]             b_byte;
    logic                   rd_en, wr_en;
    logic [7:0]             rd_data;

    lzbd_ram #(
        .WIDTH(8),
        .DEPTH(HISTORY_BYTES)
    ) u_hist (
        .i_clk    (i_clk),
        .i_wr_en  (wr_en),
        .i_wr_addr(r_b_wp),
        .i_wr_data(b_byte),
        .i_rd_en  (rd_en),
        .i_rd_addr(src),
        .o_rd_data(rd_data)
    );

    always_comb begin
        case (r_phase)
            PH_LITCNT: len = r_glit;
            PH_DIST:   len = r_gdist;
            default:   len = r_gcnt;
        endcase
        need     = {1'b0, len} + 6'd1;
        dec_pend = ((r_phase == PH_FLAG) && (r_cnt != 7'd0)) ||
                   ((r_phase inside {PH_LITCNT, PH_DIST, PH_CNT}) &&
                    (r_cnt >= {1'b0, need}));
        is_blk   = (i_mode == MODE_BLOCK);
        b_go     = r_b_valid && (!r_out_valid || i_out_ready);
        o_in_ready = (!r_b_valid || b_go) && (is_blk || !dec_pend);
        acc      = i_in_valid && o_in_ready;

        chunk = r_buf[31:0] & ((32'd1 << len) - 32'd1);
        more  = r_buf[len];
        wide  = {32'd0, chunk} << r_nshift[4:0];
        csat  = (chunk != 32'd0) && (r_nshift[5] || ((wide >> AW) != 64'd0));
        if (chunk == 32'd0) begin
            fv = r_num;
        end else if (csat) begin
            fv = '1;
        end else begin
            fv = r_num | wide[AW-1:0];
        end
        shsum = {1'b0, r_nshift} + {2'b0, len};

        src = r_wp - r_dist[AW-1:0];

        if (!r_b.byte_valid) begin
            b_byte = 8'd0;
        end else if (!r_b.is_copy) begin
            b_byte = r_b.lit;
        end else if (r_b.fwd) begin
            b_byte = r_fwd_byte;
        end else begin
            b_byte = rd_data;
        end
        wr_en = b_go && r_b.byte_valid;
        rd_en = 1'b0;

        n_buf = r_buf;   n_cnt = r_cnt;
        n_glit = r_glit; n_gdist = r_gdist; n_gcnt = r_gcnt;
        n_phase = r_phase; n_num = r_num; n_nshift = r_nshift;
        n_dist = r_dist; n_run = r_run; n_brem = r_brem; n_wp = r_wp;
        n_tovf = r_tovf; n_blen = r_blen; n_minm = r_minm;
        n_b_valid = r_b_valid; n_b = r_b; n_b_wp = r_b_wp;
        n_fwd_byte = r_fwd_byte;
        n_out_valid = r_out_valid; n_out = r_out;

        o_cfg_ready = 1'b1;
        if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_BLOCK_LENGTH: n_blen = i_cfg_data;
                CFG_MIN_MATCH:    n_minm = i_cfg_data[MIN_MATCH_W-1:0];
                default:          n_blen = r_blen;
            endcase
        end

        // decode one flag or chunk ahead of a waiting tick
        if (i_in_valid && !is_blk && dec_pend) begin
            if (r_phase == PH_FLAG) begin
                n_buf    = r_buf >> 1;
                n_cnt    = r_cnt - 7'd1;
                n_tovf   = 1'b0;
                n_num    = '0;
                n_nshift = 6'd0;
                n_phase  = r_buf[0] ? PH_DIST : PH_LITCNT;
            end else begin
                n_buf    = r_buf >> need;
                n_cnt    = r_cnt - {1'b0, need};
                n_tovf   = r_tovf | csat;
                n_num    = fv;
                n_nshift = shsum[6] ? 6'd63 : shsum[5:0];
                if (!more) begin
                    n_num    = '0;
                    n_nshift = 6'd0;
                    case (r_phase)
                        PH_LITCNT: begin
                            n_run   = {1'b0, fv} + (AW+1)'(1);
                            n_phase = PH_LITBYTES;
                        end
                        PH_DIST: begin
                            n_dist  = {1'b0, fv} + (AW+1)'(1);
                            n_phase = PH_CNT;
                        end
                        default: begin
                            n_run   = {1'b0, fv} + (AW+1)'(r_minm);
                            n_phase = (n_run == '0) ? PH_FLAG : PH_COPY;
                        end
                    endcase
                end
            end
        end

        if (b_go) begin
            n_out_valid     = 1'b1;
            n_out.taken     = r_b.taken;
            n_out.byte_valid = r_b.byte_valid;
            n_out.data      = b_byte;
            n_out.last      = r_b.last;
            n_out.ovf       = r_b.ovf;
            n_b_valid       = 1'b0;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end

        if (acc) begin
            n_b_valid  = 1'b1;
            n_b        = '0;
            n_b_wp     = r_wp;
            n_fwd_byte = b_byte;
            if (is_blk) begin
                n_b.taken = 1'b1;
                n_glit    = i_data_word[4:0];
                n_gdist   = i_data_word[9:5];
                n_gcnt    = i_data_word[14:10];
                n_buf     = {47'd0, i_data_word[31:15]};
                n_cnt     = 7'd17;
                n_num     = '0;
                n_nshift  = 6'd0;
                n_run     = '0;
                n_tovf    = 1'b0;
                n_brem    = r_blen;
                n_phase   = (r_blen == '0) ? PH_IDLE : PH_FLAG;
            end else if ((r_phase == PH_COPY) ||
                         ((r_phase == PH_LITBYTES) && (r_cnt >= 7'd8))) begin
                n_b.byte_valid = 1'b1;
                n_b.ovf        = r_tovf;
                if (r_phase == PH_LITBYTES) begin
                    n_b.lit = r_buf[7:0];
                    n_buf   = r_buf >> 8;
                    n_cnt   = r_cnt - 7'd8;
                end else begin
                    n_b.is_copy = 1'b1;
                    rd_en       = 1'b1;
                    n_b.fwd     = r_b_valid && r_b.byte_valid && (src == r_b_wp);
                end
                n_wp   = r_wp + AW'(1);
                n_run  = r_run - (AW+1)'(1);
                n_brem = r_brem - BLOCK_LEN_W'(1);
                if (r_run == (AW+1)'(1)) begin
                    n_phase = PH_FLAG;
                end
                if (r_brem == BLOCK_LEN_W'(1)) begin
                    n_b.last = 1'b1;
                    n_phase  = PH_IDLE;
                    n_buf    = 64'd0;
                    n_cnt    = 7'd0;
                end
            end else if ((i_mode == MODE_WORD) && (r_phase != PH_IDLE) &&
                         (r_cnt <= 7'd32)) begin
                n_b.taken = 1'b1;
                n_buf     = r_buf | ({32'd0, i_data_word} << r_cnt[5:0]);
                n_cnt     = r_cnt + 7'd32;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_buf       <= 64'd0;
            r_cnt       <= 7'd0;
            r_glit      <= 5'd0;
            r_gdist     <= 5'd0;
            r_gcnt      <= 5'd0;
            r_phase     <= PH_IDLE;
            r_num       <= '0;
            r_nshift    <= 6'd0;
            r_dist      <= '0;
            r_run       <= '0;
            r_brem      <= '0;
            r_wp        <= '0;
            r_tovf      <= 1'b0;
            r_blen      <= BLOCK_LEN_W'(65536);
            r_minm      <= MIN_MATCH_W'(3);
            r_b_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_buf       <= n_buf;
            r_cnt       <= n_cnt;
            r_glit      <= n_glit;
            r_gdist     <= n_gdist;
            r_gcnt      <= n_gcnt;
            r_phase     <= n_phase;
            r_num       <= n_num;
            r_nshift    <= n_nshift;
            r_dist      <= n_dist;
            r_run       <= n_run;
            r_brem      <= n_brem;
            r_wp        <= n_wp;
            r_tovf      <= n_tovf;
            r_blen      <= n_blen;
            r_minm      <= n_minm;
            r_b_valid   <= n_b_valid;
            r_out_valid <= n_out_valid;
        end
        r_b        <= n_b;
        r_b_wp     <= n_b_wp;
        r_fwd_byte <= n_fwd_byte;
        r_out      <= n_out;
    end

    assign o_out_valid  = r_out_valid;
    assign o_word_taken = r_out.taken;
    assign o_byte_valid = r_out.byte_valid;
    assign o_out_byte   = r_out.data;
    assign o_block_end  = r_out.last;
    assign o_overflow   = r_out.ovf;

endmodule

@@ hdl/lzbd_checker.sv @@
`timescale 1ns / 1ps
// Port-level assertions for the decompressor, bound to the top level.
// Depends on lzbd_pkg and lz77_bit_packed_decompressor.
module lzbd_checker
    import lzbd_pkg::*;
(
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_in_valid,
    input logic                   o_in_ready,
    input logic [1:0]             i_mode,
    input logic [31:0]            i_data_word,
    input logic                   o_out_valid,
    input logic                   i_out_ready,
    input logic                   o_word_taken,
    input logic                   o_byte_valid,
    input logic [7:0]             o_out_byte,
    input logic                   o_block_end,
    input logic                   o_overflow,
    input logic                   i_cfg_valid,
    input logic                   o_cfg_ready,
    input logic                   i_cfg_index,
    input logic [BLOCK_LEN_W-1:0] i_cfg_data
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_byte) &&
        $stable(o_byte_valid) && $stable(o_word_taken) && $stable(o_block_end))
        else $error("output transfer changed while stalled");

    a_idle_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_byte_valid |-> (o_out_byte == 8'd0) && !o_block_end && !o_overflow)
        else $error("byte fields set without a byte");

    a_one_action: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_word_taken && o_byte_valid))
        else $error("word taken and byte emitted in one tick");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result present after reset");

endmodule

bind lz77_bit_packed_decompressor lzbd_checker u_lzbd_checker (.*);

@@ sim/testbench.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for lz77_bit_packed_decompressor: builds coded blocks,
// predicts every tick's result in a behavioral decoder and checks the output stream.
// Depends on lzbd_pkg and the decompressor RTL.
module testbench;
    import lzbd_pkg::*;

    localparam int HIST = 65536;
    localparam int CAP = HIST - 1;
    localparam int LIMIT = 600000;
    localparam int SETTLE = 12;
    localparam logic [1:0] MODE_SPARE = 2'd3;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [1:0]  i_mode;
    logic [31:0] i_data_word;
    logic        o_out_valid;
    logic        i_out_ready;
    logic        o_word_taken;
    logic        o_byte_valid;
    logic [7:0]  o_out_byte;
    logic        o_block_end;
    logic        o_overflow;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic        i_cfg_index;
    logic [BLOCK_LEN_W-1:0] i_cfg_data;

    lz77_bit_packed_decompressor dut (.*);

    logic in_fire, out_fire, cfg_fire;
    int   cycles;
    int   errors;
    bit   quiet;
    int   ticks_sent;
    t_result result_q[$];

    // decoder image
    logic [16:0] dec_blen;
    logic [3:0]  dec_mmatch;
    logic [63:0] dec_buf;
    int          dec_cnt;
    int          dec_lw, dec_dw, dec_cw;
    t_phase      dec_ph;
    int          dec_val, dec_shift, dec_dist, dec_left, dec_wp, dec_run, dec_written;
    bit          dec_ovf;
    logic [7:0]  dec_hist [0:HIST-1];

    initial begin
        i_clk = 0;
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        in_fire  <= i_in_valid && o_in_ready;
        out_fire <= o_out_valid && i_out_ready;
        cfg_fire <= i_cfg_valid && o_cfg_ready;
        cycles   <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic flag_error(input string msg);
        errors++;
        if (errors <= 10) $display("mismatch: %s", msg);
    endtask

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (result_q.size() == 0) begin
                flag_error("result with nothing expected");
            end else begin
                want = result_q.pop_front();
                if (want.taken !== o_word_taken || want.byte_valid !== o_byte_valid ||
                    want.data !== o_out_byte || want.last !== o_block_end ||
                    want.ovf !== o_overflow)
                    flag_error($sformatf("exp taken=%0b valid=%0b byte=%02h end=%0b ovf=%0b, got %0b %0b %02h %0b %0b",
                        want.taken, want.byte_valid, want.data, want.last, want.ovf,
                        o_word_taken, o_byte_valid, o_out_byte, o_block_end, o_overflow));
            end
        end
    end

    initial begin
        int n;
        i_out_ready = 0;
        @(posedge i_rst_n);
        forever begin
            n = quiet ? 0 : $urandom_range(0, 7);
            if (n > 0) begin
                i_out_ready <= 0;
                repeat (n) @(negedge i_clk);
            end
            i_out_ready <= 1;
            do @(negedge i_clk); while (!out_fire);
        end
    end

    function automatic void add_chunk(input logic [31:0] chunk, input int len);
        logic [63:0] v;
        if (chunk != 0) begin
            if (dec_shift >= 32) begin
                dec_val = CAP;
                dec_ovf = 1;
            end else begin
                v = 64'(dec_val) | (64'(chunk) << dec_shift);
                if (v > CAP) begin
                    dec_val = CAP;
                    dec_ovf = 1;
                end else begin
                    dec_val = int'(v);
                end
            end
        end
        dec_shift += len;
        if (dec_shift > 63) dec_shift = 63;
    endfunction

    function automatic void close_number();
        int v;
        v = dec_val;
        dec_val = 0;
        dec_shift = 0;
        if (dec_ph == PH_LITCNT) begin
            dec_run = v + 1;
            dec_ph = PH_LITBYTES;
        end else if (dec_ph == PH_DIST) begin
            dec_dist = v + 1;
            dec_ph = PH_CNT;
        end else begin
            dec_run = v + dec_mmatch;
            dec_ph = (dec_run == 0) ? PH_FLAG : PH_COPY;
        end
    endfunction

    function automatic void decode_buffered();
        int len;
        logic [31:0] chunk;
        bit more;
        while (1) begin
            if (dec_ph == PH_FLAG) begin
                if (dec_cnt < 1) break;
                dec_ph = dec_buf[0] ? PH_DIST : PH_LITCNT;
                dec_buf >>= 1;
                dec_cnt--;
                dec_ovf = 0;
                dec_val = 0;
                dec_shift = 0;
            end else if (dec_ph == PH_LITCNT || dec_ph == PH_DIST || dec_ph == PH_CNT) begin
                len = (dec_ph == PH_LITCNT) ? dec_lw : (dec_ph == PH_DIST) ? dec_dw : dec_cw;
                if (dec_cnt < len + 1) break;
                chunk = 32'(dec_buf & ((64'd1 << len) - 1));
                more = dec_buf[len];
                dec_buf >>= (len + 1);
                dec_cnt -= len + 1;
                add_chunk(chunk, len);
                if (!more) close_number();
            end else begin
                break;
            end
        end
    endfunction

    function automatic t_result decode_tick(input logic [1:0] mode, input logic [31:0] word);
        t_result r;
        r = '0;
        if (mode == MODE_BLOCK) begin
            r.taken = 1;
            dec_lw = word[4:0];
            dec_dw = word[9:5];
            dec_cw = word[14:10];
            dec_buf = 64'(word[31:15]);
            dec_cnt = 17;
            dec_val = 0;
            dec_shift = 0;
            dec_run = 0;
            dec_ovf = 0;
            dec_left = dec_blen;
            dec_ph = (dec_left == 0) ? PH_IDLE : PH_FLAG;
        end else begin
            decode_buffered();
            if (dec_ph == PH_COPY || (dec_ph == PH_LITBYTES && dec_cnt >= 8)) begin
                if (dec_ph == PH_LITBYTES) begin
                    r.data = dec_buf[7:0];
                    dec_buf >>= 8;
                    dec_cnt -= 8;
                end else begin
                    r.data = dec_hist[(dec_wp + HIST - dec_dist) % HIST];
                end
                dec_hist[dec_wp] = r.data;
                dec_wp = (dec_wp + 1) % HIST;
                if (dec_written < HIST) dec_written++;
                r.byte_valid = 1;
                r.ovf = dec_ovf;
                dec_run--;
                dec_left--;
                if (dec_run == 0) dec_ph = PH_FLAG;
                if (dec_left == 0) begin
                    r.last = 1;
                    dec_ph = PH_IDLE;
                    dec_buf = 0;
                    dec_cnt = 0;
                end
            end else if (mode == MODE_WORD && dec_ph != PH_IDLE && dec_cnt <= 32) begin
                r.taken = 1;
                dec_buf |= 64'(word) << dec_cnt;
                dec_cnt += 32;
            end
        end
        return r;
    endfunction

    // send one tick; report whether the word was taken
    task automatic send_tick(input logic [1:0] mode, input logic [31:0] word, output bit taken);
        int n;
        t_result r;
        n = quiet ? 0 : $urandom_range(0, 7);
        if (n > 0) begin
            i_in_valid <= 0;
            repeat (n) @(negedge i_clk);
        end
        i_mode <= mode;
        i_data_word <= word;
        i_in_valid <= 1;
        do @(negedge i_clk); while (!in_fire);
        r = decode_tick(mode, word);
        taken = r.taken;
        result_q.push_back(r);
        ticks_sent++;
    endtask

    task automatic drain_results();
        i_in_valid <= 0;
        do @(negedge i_clk); while (result_q.size() != 0);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [16:0] value);
        drain_results();
        i_cfg_index <= idx;
        i_cfg_data <= value;
        i_cfg_valid <= 1;
        do @(negedge i_clk); while (!cfg_fire);
        i_cfg_valid <= 0;
        if (idx == CFG_BLOCK_LENGTH) dec_blen = value;
        else dec_mmatch = value[3:0];
    endtask

    function automatic void put_number(ref bit bits[$], input longint v, input int w);
        if (w == 0) v = 0;
        do begin
            for (int i = 0; i < w; i++) bits.push_back(v[i]);
            v = v >> w;
            bits.push_back(v != 0);
        end while (v != 0);
    endfunction

    // build one coded block with the given group widths and send it;
    // cut_at > 0 drops the rest of the block after cut_at - 1 stream words
    task automatic send_block(input int lw, input int dw, input int cw,
                              input int ovf_pct, input int cut_at);
        bit bits[$];
        logic [31:0] words[$];
        logic [31:0] w;
        longint v;
        int need, made, hist, d, k;
        bit taken, ovf;
        need = dec_blen;
        made = 0;
        hist = dec_written;
        while (made < need) begin
            ovf = ($urandom_range(0, 99) < ovf_pct);
            if (hist + made > 0 && $urandom_range(0, 1)) begin
                bits.push_back(1);
                d = $urandom_range(1, (hist + made > 64) ? 64 : hist + made);
                if (dw == 0) d = 1;
                put_number(bits, d - 1, dw);
                v = (ovf && cw > 0) ? (longint'(1) << $urandom_range(16, 39)) | $urandom
                                    : $urandom_range(0, 8);
                if (cw == 0) v = 0;
                put_number(bits, v, cw);
                made += ((v > CAP) ? CAP : int'(v)) + dec_mmatch;
            end else begin
                bits.push_back(0);
                v = (ovf && lw > 0) ? (longint'(1) << $urandom_range(16, 39)) | $urandom
                                    : $urandom_range(0, 5);
                if (lw == 0) v = 0;
                put_number(bits, v, lw);
                k = ((v > CAP) ? CAP : int'(v)) + 1;
                if (k > need - made) k = need - made;
                for (int i = 0; i < k; i++) begin
                    w[7:0] = (i == 0) ? 8'h00 : (i == 1) ? 8'hFF : 8'($urandom);
                    for (int b = 0; b < 8; b++) bits.push_back(w[b]);
                end
                made += k;
            end
        end
        w = $urandom;
        w[4:0] = 5'(lw);
        w[9:5] = 5'(dw);
        w[14:10] = 5'(cw);
        for (int i = 0; i < 17 && bits.size() > 0; i++) w[15 + i] = bits.pop_front();
        words.push_back(w);
        while (bits.size() > 0) begin
            w = $urandom;
            for (int i = 0; i < 32 && bits.size() > 0; i++) w[i] = bits.pop_front();
            words.push_back(w);
        end
        send_tick(MODE_BLOCK, words[0], taken);
        for (int i = 1; i < words.size(); i++) begin
            if (cut_at > 0 && i == cut_at) return;
            if ($urandom_range(0, 4) == 0)
                send_tick($urandom_range(0, 1) ? MODE_IDLE : MODE_SPARE, $urandom, taken);
            do send_tick(MODE_WORD, words[i], taken);
            while (!taken && dec_ph != PH_IDLE);
            if (dec_ph == PH_IDLE) break;
        end
        k = 0;
        while (dec_ph != PH_IDLE && k < 400) begin
            send_tick(MODE_IDLE, $urandom, taken);
            k++;
        end
    endtask

    task automatic test_reset_config_and_abort();
        bit taken;
        send_tick(MODE_WORD, 32'hFFFF_FFFF, taken);
        send_tick(MODE_SPARE, 32'h0, taken);
        send_block(3, 4, 2, 0, 2);
        send_block(2, 3, 2, 0, 3);
        send_block(31, 31, 31, 0, 2);
    endtask

    task automatic test_block_length_extremes();
        bit taken;
        write_reg(CFG_BLOCK_LENGTH, 17'd0);
        send_tick(MODE_BLOCK, 32'hFFFF_FFFF, taken);
        send_tick(MODE_WORD, 32'h0, taken);
        write_reg(CFG_BLOCK_LENGTH, 17'd1);
        send_block(0, 0, 0, 0, 0);
        write_reg(CFG_BLOCK_LENGTH, 17'h1FFFF);
        send_block(1, 2, 1, 0, 3);
        write_reg(CFG_BLOCK_LENGTH, 17'd65536);
        send_block(4, 5, 3, 0, 2);
    endtask

    task automatic test_copy_counts();
        write_reg(CFG_BLOCK_LENGTH, 17'd40);
        write_reg(CFG_MIN_MATCH, 17'd0);
        send_block(2, 3, 2, 0, 0);
        send_block(0, 0, 0, 0, 0);
        write_reg(CFG_MIN_MATCH, 17'd15);
        send_block(3, 6, 2, 0, 0);
    endtask

    task automatic test_saturation();
        write_reg(CFG_BLOCK_LENGTH, 17'd24);
        write_reg(CFG_MIN_MATCH, 17'd2);
        send_block(1, 4, 1, 60, 0);
        send_block(31, 8, 31, 50, 0);
    endtask

    task automatic test_random_blocks();
        int wmax;
        quiet = 0;
        while (ticks_sent < 450) begin
            quiet = ($urandom_range(0, 5) == 0);
            if ($urandom_range(0, 2) == 0) write_reg(CFG_MIN_MATCH, 17'($urandom_range(0, 15)));
            write_reg(CFG_BLOCK_LENGTH, $urandom_range(0, 9) == 0 ? 17'($urandom_range(0, 200))
                                                                 : 17'($urandom_range(1, 48)));
            wmax = $urandom_range(0, 3) == 0 ? 31 : 6;
            send_block($urandom_range(0, wmax), $urandom_range(0, wmax),
                       $urandom_range(0, wmax), $urandom_range(0, 1) ? 10 : 0,
                       $urandom_range(0, 7) == 0 ? $urandom_range(1, 4) : 0);
            if ($urandom_range(0, 9) == 0) drain_results();
        end
        quiet = 0;
    endtask

    initial begin
        errors = 0;
        cycles = 0;
        ticks_sent = 0;
        quiet = 0;
        i_rst_n = 0;
        i_in_valid = 0;
        i_mode = MODE_IDLE;
        i_data_word = 0;
        i_cfg_valid = 0;
        i_cfg_index = CFG_BLOCK_LENGTH;
        i_cfg_data = 0;
        dec_blen = 17'd65536;
        dec_mmatch = 4'd3;
        dec_buf = 0;
        dec_cnt = 0;
        dec_lw = 0;
        dec_dw = 0;
        dec_cw = 0;
        dec_ph = PH_IDLE;
        dec_val = 0;
        dec_shift = 0;
        dec_dist = 0;
        dec_left = 0;
        dec_wp = 0;
        dec_run = 0;
        dec_written = 0;
        dec_ovf = 0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1;
        @(negedge i_clk);
        test_reset_config_and_abort();
        test_block_length_extremes();
        test_copy_counts();
        test_saturation();
        test_random_blocks();
        drain_results();
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule

@@ filelist.f @@
hdl/lzbd_pkg.sv
hdl/lzbd_ram.sv
hdl/lz77_bit_packed_decompressor.sv
hdl/lzbd_checker.sv
sim/testbench.sv
